// File: rtl/core/rv32alu_pkg.sv
// Package for the RV32 integer ALU core step block.
// Holds widths, opcode and funct3 codes, result status codes and the
// structs shared by the core modules. No dependencies.
package rv32alu_pkg;

    localparam int XLEN      = 32;
    localparam int REG_DEPTH = 32;
    localparam int REG_AW    = 5;

    // Opcodes and fixed encodings
    localparam logic [6:0]      OPC_R      = 7'h33;
    localparam logic [6:0]      OPC_I      = 7'h13;
    localparam logic [XLEN-1:0] ECALL_WORD = 32'h0000_0073;

    // funct3 codes of the supported ALU operations
    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_XOR = 3'd4;
    localparam logic [2:0] F3_OR  = 3'd6;
    localparam logic [2:0] F3_AND = 3'd7;

    // Architectural register indexes
    localparam logic [REG_AW-1:0] ZERO_IDX = 5'd0;
    localparam logic [REG_AW-1:0] SP_IDX   = 5'd2;
    localparam logic [REG_AW-1:0] A0_IDX   = 5'd10;

    localparam logic [XLEN-1:0] PC_STEP = 32'd4;

    // Result status codes
    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_REJECTED  = 3'd1,
        ST_HALTED    = 3'd2,
        ST_ECALL_ERR = 3'd3,
        ST_IGNORED   = 3'd4
    } status_t;

    // Register file write request
    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [XLEN-1:0]   data;
    } rf_wr_t;

    // Outcome of executing one transaction
    typedef struct packed {
        status_t           status;
        logic [XLEN-1:0]   pc;
        logic              we;
        logic [REG_AW-1:0] rd;
        logic [XLEN-1:0]   value;
        logic [XLEN-1:0]   err;
        logic              pc_adv;
        logic              halt_set;
        logic              restart;
    } exec_res_t;

endpackage

// File: rtl/core/rv32alu_if.sv
// Handshake interfaces for the RV32 ALU core step: command in, result out.
// Depends on nothing; widths follow the field definitions.
interface rv32alu_cmd_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] instruction_word;

    modport source (output valid, action, instruction_word, input ready);
    modport sink   (input valid, action, instruction_word, output ready);
endinterface

interface rv32alu_rsp_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  status;
    logic        [31:0] instruction_pc;
    logic               write_enable;
    logic        [4:0]  dest_register;
    logic signed [31:0] write_value;
    logic signed [31:0] error_code;

    modport source (output valid, status, instruction_pc, write_enable, dest_register,
                    write_value, error_code, input ready);
    modport sink   (input valid, status, instruction_pc, write_enable, dest_register,
                    write_value, error_code, output ready);
endinterface

// File: rtl/core/rv32_integer_alu_core_step.sv
// Top level of the RV32 integer ALU core step block.
// Depends on rv32alu_pkg, rv32alu_if, rv32alu_regfile and rv32alu_exec.
//
// Executes one RV32I ALU instruction (ADD/SUB/AND/OR/XOR and the immediate
// forms) or ECALL per command transaction, or restarts the core state.
// Throughput is one transaction per clock cycle while rsp is not stalled; a
// result passes the s1 and output registers on its way to rsp. The register
// file is a synchronous RAM: its read is issued in the cycle the command is
// taken, and execution with writeback happens as the command leaves s1, with
// the previous write bypassed to the read. Restart clears the per-entry valid
// bits at once; no clearing pass follows reset. The result sits in an output
// register, so a new command is taken while a result waits for rsp.ready. The
// stack pointer restart value, written by the user via cfg_we/cfg_wdata while
// the block is idle (the block does not enforce it), applies at next restart.
module rv32_integer_alu_core_step
    import rv32alu_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    rv32alu_cmd_if.sink         cmd,
    rv32alu_rsp_if.source       rsp,
    input  logic                cfg_we,
    input  logic [XLEN-1:0]     cfg_wdata
);

    logic              s1_valid_reg;
    logic              s1_action_reg;
    logic [XLEN-1:0]   s1_word_reg;
    logic [XLEN-1:0]   pc_reg;
    logic [XLEN-1:0]   pc_next;
    logic              halted_reg;
    logic              halted_next;
    logic [XLEN-1:0]   sp_cfg_reg;
    logic              rsp_valid_reg;
    exec_res_t         out_reg;
    logic              accept;
    logic              s1_fire;
    logic [REG_AW-1:0] rd_addr_a;
    logic [XLEN-1:0]   op_a;
    logic [XLEN-1:0]   op_b;
    exec_res_t         res;
    rf_wr_t            rf_wr;

    // Handshake
    assign s1_fire   = s1_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign cmd.ready = !s1_valid_reg || s1_fire;
    assign accept    = cmd.valid && cmd.ready;

    // Ecall reads x10 on port A
    assign rd_addr_a = (cmd.instruction_word == ECALL_WORD) ? A0_IDX
                                                            : cmd.instruction_word[19:15];

    rv32alu_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (cmd.instruction_word[24:20]),
        .wr        (rf_wr),
        .clear     (s1_fire && res.restart),
        .sp_value  (sp_cfg_reg),
        .rd_data_a (op_a),
        .rd_data_b (op_b)
    );

    rv32alu_exec u_exec (
        .action (s1_action_reg),
        .word   (s1_word_reg),
        .pc     (pc_reg),
        .halted (halted_reg),
        .op_a   (op_a),
        .op_b   (op_b),
        .res    (res)
    );

    // Writeback request
    always_comb
    begin
        rf_wr.en   = s1_fire && res.we;
        rf_wr.addr = res.rd;
        rf_wr.data = res.value;
    end

    // pc and halt update
    always_comb
    begin
        pc_next     = pc_reg;
        halted_next = halted_reg;
        if (s1_fire)
        begin
            if (res.restart)
            begin
                pc_next     = '0;
                halted_next = 1'b0;
            end
            else
            begin
                if (res.pc_adv)
                begin
                    pc_next = pc_reg + PC_STEP;
                end
                if (res.halt_set)
                begin
                    halted_next = 1'b1;
                end
            end
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            pc_reg        <= '0;
            halted_reg    <= 1'b0;
            sp_cfg_reg    <= '0;
        end
        else
        begin
            if (cmd.ready)
            begin
                s1_valid_reg <= cmd.valid;
            end
            if (s1_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            pc_reg     <= pc_next;
            halted_reg <= halted_next;
            if (cfg_we)
            begin
                sp_cfg_reg <= cfg_wdata;
            end
        end
    end

    // Command and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_action_reg <= cmd.action;
            s1_word_reg   <= cmd.instruction_word;
        end
        if (s1_fire)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = out_reg.status;
    assign rsp.instruction_pc = out_reg.pc;
    assign rsp.write_enable   = out_reg.we;
    assign rsp.dest_register  = out_reg.rd;
    assign rsp.write_value    = out_reg.value;
    assign rsp.error_code     = out_reg.err;

endmodule

// File: rtl/core/rv32alu_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Read during write to the same address returns the old contents.
// No dependencies.
module rv32alu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Storage write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/rv32alu_regfile.sv
// Register file of the RV32 ALU core: two RAM copies for two read ports,
// per-entry valid bits for an immediate restart, and a bypass of the last write.
// Depends on rv32alu_pkg and rv32alu_ram.
module rv32alu_regfile
    import rv32alu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [REG_AW-1:0] rd_addr_a,
    input  logic [REG_AW-1:0] rd_addr_b,
    input  rf_wr_t            wr,
    input  logic              clear,
    input  logic [XLEN-1:0]   sp_value,
    output logic [XLEN-1:0]   rd_data_a,
    output logic [XLEN-1:0]   rd_data_b
);

    logic [REG_DEPTH-1:0] valid_reg;
    logic [REG_DEPTH-1:0] valid_next;
    rf_wr_t               wb_reg;
    logic [XLEN-1:0]      sp_init_reg;
    logic [REG_AW-1:0]    addr_a_reg;
    logic [REG_AW-1:0]    addr_b_reg;
    logic [XLEN-1:0]      ram_a;
    logic [XLEN-1:0]      ram_b;

    // Two copies written together, one per read port
    rv32alu_ram #(.WIDTH(XLEN), .DEPTH(REG_DEPTH)) u_ram_a (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd_en),
        .raddr (rd_addr_a),
        .rdata (ram_a)
    );

    rv32alu_ram #(.WIDTH(XLEN), .DEPTH(REG_DEPTH)) u_ram_b (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd_en),
        .raddr (rd_addr_b),
        .rdata (ram_b)
    );

    // Read addresses follow the RAM output registers
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            addr_a_reg <= rd_addr_a;
            addr_b_reg <= rd_addr_b;
        end
    end

    // Valid bits: restart clears all, a write marks its entry
    always_comb
    begin
        valid_next = valid_reg;
        if (clear)
        begin
            valid_next = '0;
        end
        else if (wr.en)
        begin
            valid_next[wr.addr] = 1'b1;
        end
    end

    // Valid bits, restart value of x2, and the last write kept for the
    // read that overlapped it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            wb_reg      <= '0;
            sp_init_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (clear)
            begin
                wb_reg.en   <= 1'b0;
                sp_init_reg <= sp_value;
            end
            else if (wr.en)
            begin
                wb_reg <= wr;
            end
        end
    end

    // Resolve: bypass, then RAM if written since restart, else reset value
    always_comb
    begin
        if (wb_reg.en && (wb_reg.addr == addr_a_reg))
        begin
            rd_data_a = wb_reg.data;
        end
        else if (valid_reg[addr_a_reg])
        begin
            rd_data_a = ram_a;
        end
        else if (addr_a_reg == SP_IDX)
        begin
            rd_data_a = sp_init_reg;
        end
        else
        begin
            rd_data_a = '0;
        end
    end

    always_comb
    begin
        if (wb_reg.en && (wb_reg.addr == addr_b_reg))
        begin
            rd_data_b = wb_reg.data;
        end
        else if (valid_reg[addr_b_reg])
        begin
            rd_data_b = ram_b;
        end
        else if (addr_b_reg == SP_IDX)
        begin
            rd_data_b = sp_init_reg;
        end
        else
        begin
            rd_data_b = '0;
        end
    end

endmodule

// File: rtl/core/rv32alu_exec.sv
// Decode and ALU of the RV32 ALU core: turns one transaction, the current
// pc and halt flag, and the operand values into a result and state update.
// Depends on rv32alu_pkg.
module rv32alu_exec
    import rv32alu_pkg::*;
(
    input  logic            action,
    input  logic [XLEN-1:0] word,
    input  logic [XLEN-1:0] pc,
    input  logic            halted,
    input  logic [XLEN-1:0] op_a,
    input  logic [XLEN-1:0] op_b,
    output exec_res_t       res
);

    logic [6:0]        opc;
    logic [2:0]        f3;
    logic [6:0]        f7;
    logic [REG_AW-1:0] rd;
    logic              is_r;
    logic              is_i;
    logic [XLEN-1:0]   b_val;
    logic [XLEN-1:0]   alu;
    logic              f3_ok;

    assign opc  = word[6:0];
    assign rd   = word[11:7];
    assign f3   = word[14:12];
    assign f7   = word[31:25];
    assign is_r = (opc == OPC_R);
    assign is_i = (opc == OPC_I);

    // Second operand: register or sign-extended 12-bit immediate
    assign b_val = is_r ? op_b : {{(XLEN-12){word[31]}}, word[31:20]};

    // ALU
    always_comb
    begin
        f3_ok = 1'b1;
        case (f3)
            F3_ADD: alu = (is_r && (f7 != 7'd0)) ? (op_a - b_val) : (op_a + b_val);
            F3_XOR: alu = op_a ^ b_val;
            F3_OR:  alu = op_a | b_val;
            F3_AND: alu = op_a & b_val;
            default:
            begin
                alu   = '0;
                f3_ok = 1'b0;
            end
        endcase
    end

    // Outcome selection
    always_comb
    begin
        res          = '0;
        res.status   = ST_DONE;
        res.pc       = pc;
        if (action)
        begin
            res.restart = 1'b1;
            res.pc      = '0;
        end
        else if (halted)
        begin
            res.status = ST_IGNORED;
        end
        else if (word == ECALL_WORD)
        begin
            // op_a holds x10 for an ecall
            res.halt_set = 1'b1;
            if (op_a == '0)
            begin
                res.status = ST_HALTED;
                res.pc_adv = 1'b1;
            end
            else
            begin
                res.status = ST_ECALL_ERR;
                res.err    = op_a;
            end
        end
        else if (!(is_r || is_i) || !f3_ok)
        begin
            res.status = ST_REJECTED;
        end
        else
        begin
            res.pc_adv = 1'b1;
            if (rd != ZERO_IDX)
            begin
                res.we    = 1'b1;
                res.rd    = rd;
                res.value = alu;
            end
        end
    end

endmodule

// File: rtl/core/rv32alu_chk.sv
// Port-level checker for the RV32 ALU core step, bound to the top level.
// Depends on rv32alu_pkg and on rv32_integer_alu_core_step's ports.
module rv32alu_chk
    import rv32alu_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [2:0]        rsp_status,
    input logic              rsp_we,
    input logic [REG_AW-1:0] rsp_rd,
    input logic [XLEN-1:0]   rsp_value,
    input logic [XLEN-1:0]   rsp_err
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_value))
        else $error("result changed while stalled");

    // x0 is never reported as written
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_we |-> rsp_rd != ZERO_IDX)
        else $error("write to x0 reported");

    // Only a completed instruction writes
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_DONE) |-> !rsp_we && rsp_value == '0)
        else $error("write on a non-completed transaction");

    // Error code only on an ecall error halt, and then nonzero
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp_status == ST_ECALL_ERR) == (rsp_err != '0)))
        else $error("error code inconsistent with status");

endmodule

bind rv32_integer_alu_core_step rv32alu_chk u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_we     (rsp.write_enable),
    .rsp_rd     (rsp.dest_register),
    .rsp_value  (rsp.write_value),
    .rsp_err    (rsp.error_code)
);
